// ----- rtl/q16da_pkg.sv -----
// q16da_pkg: shared constants, widths, types and character codes for the
// fixed-point to decimal text formatter. No dependencies.
package q16da_pkg;

    localparam int FRAC_BITS           = 15;
    localparam int MAX_FRACTION_DIGITS = 5;

    localparam int VALUE_W  = 32;
    localparam int INT_W    = VALUE_W - FRAC_BITS;
    localparam int PREC_REG_W = 4;
    localparam int BUF_REG_W  = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int CHAR_W     = 8;

    // decimal digits needed for the largest magnitude 2^(bits-1)
    function automatic int dec_digits(input int bits);
        longint m;
        int     d;
        m = longint'(1) << (bits - 1);
        d = 0;
        while (m > 0) begin
            m = m / 10;
            d++;
        end
        return d;
    endfunction

    localparam int INT_DIGITS = dec_digits(INT_W);
    localparam int BCD_W      = 4 * INT_DIGITS;
    localparam int CNT_W      = $clog2(INT_W + 1);
    localparam int ND_W       = $clog2(INT_DIGITS + 1);
    localparam int IDX_W      = (INT_DIGITS > 1) ? $clog2(INT_DIGITS) : 1;
    localparam int PREC_W     = $clog2(MAX_FRACTION_DIGITS + 1);
    localparam int NEED_W     = 9;
    localparam int PROD_W     = FRAC_BITS + 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BUF_SIZE  = CFG_IDX_W'(1);

    localparam logic [PREC_REG_W-1:0] PRECISION_RST = PREC_REG_W'(5);
    localparam logic [BUF_REG_W-1:0]  BUF_SIZE_RST  = BUF_REG_W'(16);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_CHECK,
        ST_SIGN,
        ST_INT,
        ST_DOT,
        ST_FRAC,
        ST_OVF
    } t_state;

endpackage

// ----- rtl/q16_15_to_decimal_ascii_core.sv -----
// q16_15_to_decimal_ascii_core: top level, sequencer, config registers and
// output register. Depends on q16da_pkg, q16da_dabble, q16da_frac.
//
//  channel   dir   handshake                   payload
//  in        in    i_in_valid / o_in_ready     i_fixed_value
//  out       out   o_out_valid / i_out_ready   o_ascii_char, o_last, o_overflow
//  cfg       in    i_cfg_we                    i_cfg_idx, i_cfg_wdata
//
// a value yields up to 12 characters here; the serial bcd converter takes one
// integer bit per cycle.
// one value is in flight at a time; o_in_ready is high only when idle.
// each output stall holds the sequencer for that cycle.
// synchronous active-low reset: precision 5, buffer size 16, output empty.
module q16_15_to_decimal_ascii_core import q16da_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [VALUE_W-1:0]    i_fixed_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAR_W-1:0]     o_ascii_char,
    output logic                  o_last,
    output logic                  o_overflow,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_state                r_state, n_state;
    logic [PREC_REG_W-1:0] r_precision;
    logic [BUF_REG_W-1:0]  r_buf_size;
    logic                  r_neg;
    logic [PREC_W-1:0]     r_prec;
    logic [IDX_W-1:0]      r_idx;
    logic [PREC_W-1:0]     r_fcnt;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_char;
    logic                  r_last;
    logic                  r_ovf;

    logic                  conv_start;
    logic                  conv_done;
    logic                  accept;
    logic                  out_free;
    logic [INT_W-1:0]      int_part;
    logic [INT_W-1:0]      mag;
    logic [BCD_W-1:0]      bcd;
    logic [3:0]            frac_digit;
    logic [ND_W-1:0]       nd;
    logic [PREC_W-1:0]     prec_c;
    logic [NEED_W-1:0]     need;
    logic                  too_long;
    logic                  frac_last;

    logic                  emit;
    logic [CHAR_W-1:0]     emit_char;
    logic                  emit_last;
    logic                  emit_ovf;
    logic                  frac_step;

    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign conv_start = accept;

    // floor shift, then magnitude
    assign int_part = i_fixed_value[VALUE_W-1:FRAC_BITS];
    assign mag      = i_fixed_value[VALUE_W-1] ? (INT_W'(0) - int_part) : int_part;

    q16da_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (conv_start),
        .i_mag   (mag),
        .o_done  (conv_done),
        .o_bcd   (bcd)
    );

    q16da_frac u_frac (
        .i_clk   (i_clk),
        .i_load  (accept),
        .i_frac  (i_fixed_value[FRAC_BITS-1:0]),
        .i_step  (frac_step),
        .o_digit (frac_digit)
    );

    // significant integer digits, at least one
    always_comb begin
        nd = ND_W'(1);
        for (int i = 1; i < INT_DIGITS; i++) begin
            if (bcd[i*4 +: 4] != 4'd0) begin
                nd = ND_W'(i + 1);
            end
        end
    end

    assign prec_c = (r_precision > PREC_REG_W'(MAX_FRACTION_DIGITS))
                  ? PREC_W'(MAX_FRACTION_DIGITS) : PREC_W'(r_precision);
    assign need   = NEED_W'(r_neg) + NEED_W'(nd) + NEED_W'(prec_c) + NEED_W'(2);
    assign too_long  = need > NEED_W'(r_buf_size);
    assign frac_last = (r_fcnt + PREC_W'(1)) == r_prec;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept) n_state = ST_CONV;
            ST_CONV:  if (conv_done) n_state = ST_CHECK;
            ST_CHECK: begin
                if (too_long)   n_state = ST_OVF;
                else if (r_neg) n_state = ST_SIGN;
                else            n_state = ST_INT;
            end
            ST_SIGN:  if (out_free) n_state = ST_INT;
            ST_INT:   if (out_free && r_idx == '0) n_state = ST_DOT;
            ST_DOT: begin
                if (out_free) n_state = (r_prec == '0) ? ST_IDLE : ST_FRAC;
            end
            ST_FRAC:  if (out_free && frac_last) n_state = ST_IDLE;
            ST_OVF:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        emit       = 1'b0;
        emit_char  = CH_NUL;
        emit_last  = 1'b0;
        emit_ovf   = 1'b0;
        frac_step  = 1'b0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_SIGN: begin
                emit      = out_free;
                emit_char = CH_MINUS;
            end
            ST_INT: begin
                emit      = out_free;
                emit_char = CH_ZERO + CHAR_W'(bcd[r_idx*4 +: 4]);
            end
            ST_DOT: begin
                emit      = out_free;
                emit_char = CH_DOT;
                emit_last = (r_prec == '0);
            end
            ST_FRAC: begin
                emit      = out_free;
                frac_step = out_free;
                emit_char = CH_ZERO + CHAR_W'(frac_digit);
                emit_last = frac_last;
            end
            ST_OVF: begin
                emit      = out_free;
                emit_char = CH_NUL;
                emit_last = 1'b1;
                emit_ovf  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_precision <= PRECISION_RST;
            r_buf_size  <= BUF_SIZE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PRECISION: r_precision <= i_cfg_wdata[PREC_REG_W-1:0];
                    CFG_BUF_SIZE:  r_buf_size  <= i_cfg_wdata[BUF_REG_W-1:0];
                    default: ;
                endcase
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_neg <= i_fixed_value[VALUE_W-1];
        end
        if (r_state == ST_CHECK) begin
            r_prec <= prec_c;
            r_idx  <= IDX_W'(nd - ND_W'(1));
            r_fcnt <= '0;
        end
        if (r_state == ST_INT && out_free && r_idx != '0) begin
            r_idx <= r_idx - IDX_W'(1);
        end
        if (frac_step) begin
            r_fcnt <= r_fcnt + PREC_W'(1);
        end
        if (emit) begin
            r_char <= emit_char;
            r_last <= emit_last;
            r_ovf  <= emit_ovf;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_ascii_char = r_char;
    assign o_last       = r_last;
    assign o_overflow   = r_ovf;

endmodule

// ----- rtl/q16da_dabble.sv -----
// q16da_dabble: bit-serial binary to bcd converter (shift and add three),
// one magnitude bit per cycle. Depends on q16da_pkg.
module q16da_dabble import q16da_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [INT_W-1:0] i_mag,
    output logic             o_done,
    output logic [BCD_W-1:0] o_bcd
);

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [INT_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [BCD_W-1:0] adj;

    always_comb begin
        for (int i = 0; i < INT_DIGITS; i++) begin
            adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? r_bcd[i*4 +: 4] + 4'd3
                                                       : r_bcd[i*4 +: 4];
        end
    end

    assign o_done = r_busy && (r_cnt == CNT_W'(INT_W - 1));
    assign o_bcd  = r_bcd;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_bin  = r_bin;
        n_bcd  = r_bcd;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_bin  = i_mag;
            n_bcd  = '0;
        end else if (r_busy) begin
            n_bcd = {adj[BCD_W-2:0], r_bin[INT_W-1]};
            n_bin = {r_bin[INT_W-2:0], 1'b0};
            n_cnt = r_cnt + CNT_W'(1);
            if (o_done) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

endmodule

// ----- rtl/q16da_frac.sv -----
// q16da_frac: fraction digit generator, one decimal digit per step by a
// times-ten shift-add on the running fraction. Depends on q16da_pkg.
module q16da_frac import q16da_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic [FRAC_BITS-1:0] i_frac,
    input  logic                 i_step,
    output logic [3:0]           o_digit
);

    logic [FRAC_BITS-1:0] r_acc, n_acc;
    logic [PROD_W-1:0]    prod;

    // x*10 = x*8 + x*2
    assign prod    = (PROD_W'(r_acc) << 3) + (PROD_W'(r_acc) << 1);
    assign o_digit = prod[PROD_W-1:FRAC_BITS];

    always_comb begin
        n_acc = r_acc;
        if (i_load) begin
            n_acc = i_frac;
        end else if (i_step) begin
            n_acc = prod[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule

// ----- rtl/q16da_checker.sv -----
// q16da_checker: port-level assertions for the formatter, bound to the top
// level below. Depends on q16da_pkg.
module q16da_checker import q16da_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [CHAR_W-1:0] o_ascii_char,
    input logic              o_last,
    input logic              o_overflow
);

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_ascii_char)
            && $stable(o_last) && $stable(o_overflow))
        else $error("output beat changed while stalled");

    // overflow beat is a lone nul with last
    a_ovf_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_last && o_ascii_char == CH_NUL)
        else $error("overflow beat malformed");

    // no new value while a text is still going out
    a_no_accept_mid_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input ready during text");

    // one value at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");

endmodule

bind q16_15_to_decimal_ascii_core q16da_checker u_q16da_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_ascii_char (o_ascii_char),
    .o_last       (o_last),
    .o_overflow   (o_overflow)
);

// ----- tb/tb_q16_15_to_decimal_ascii_core.sv -----
// tb_q16_15_to_decimal_ascii_core: self-checking bench for the Q16.15 to decimal
// text formatter; predicts every output character and checks each beat in order.
// Depends on q16da_pkg and q16_15_to_decimal_ascii_core.
module tb_q16_15_to_decimal_ascii_core;
    timeunit 1ns;
    timeprecision 1ps;
    import q16da_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              ovf;
    } t_text_beat;

    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 30;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic [VALUE_W-1:0]    fixed_value = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [CHAR_W-1:0]     o_ascii_char;
    logic                  o_last;
    logic                  o_overflow;

    // shadow copies of the config registers, reset values
    logic [PREC_REG_W-1:0] cfg_precision = PRECISION_RST;
    logic [BUF_REG_W-1:0]  cfg_buf_size = BUF_SIZE_RST;

    t_text_beat expected_text[$];
    int         failures = 0;
    bit         sender_gaps_on = 1'b1;
    bit         receiver_stalls_on = 1'b1;
    int         stall_left = 0;

    q16_15_to_decimal_ascii_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_fixed_value (fixed_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_ascii_char  (o_ascii_char),
        .o_last        (o_last),
        .o_overflow    (o_overflow),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #15ms;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void queue_char(input logic [CHAR_W-1:0] ch, input logic last,
                                       input logic ovf);
        t_text_beat b;
        b.ch   = ch;
        b.last = last;
        b.ovf  = ovf;
        expected_text.push_back(b);
    endfunction

    // expected text for one value under the current register settings
    function automatic void format_value(input logic [VALUE_W-1:0] value);
        int   int_part;
        int   mag;
        int   nd;
        int   prec;
        int   need;
        int   acc;
        int   digit;
        int   digs[8];
        logic neg;
        neg      = value[VALUE_W-1];
        int_part = $signed(value) >>> FRAC_BITS;
        mag      = neg ? -int_part : int_part;
        nd       = 0;
        do begin
            digs[nd] = mag % 10;
            mag      = mag / 10;
            nd++;
        end while (mag != 0);
        prec = (int'(cfg_precision) > MAX_FRACTION_DIGITS) ? MAX_FRACTION_DIGITS
                                                           : int'(cfg_precision);
        need = int'(neg) + nd + 1 + prec + 1;
        if (need > int'(cfg_buf_size)) begin
            queue_char(CH_NUL, 1'b1, 1'b1);
            return;
        end
        if (neg)
            queue_char(CH_MINUS, 1'b0, 1'b0);
        for (int i = nd - 1; i >= 0; i--)
            queue_char(CH_ZERO + CHAR_W'(digs[i]), 1'b0, 1'b0);
        queue_char(CH_DOT, prec == 0, 1'b0);
        acc = int'(value[FRAC_BITS-1:0]);
        for (int i = 0; i < prec; i++) begin
            acc   = acc * 10;
            digit = acc >> FRAC_BITS;
            acc   = acc & ((1 << FRAC_BITS) - 1);
            queue_char(CH_ZERO + CHAR_W'(digit), i == prec - 1, 1'b0);
        end
    endfunction

    task automatic check_beat();
        t_text_beat want;
        if (expected_text.size() == 0) begin
            $error("unexpected beat: ascii_char %h last %b overflow %b",
                   o_ascii_char, o_last, o_overflow);
            failures++;
        end else begin
            want = expected_text.pop_front();
            if (o_ascii_char !== want.ch) begin
                $error("ascii_char: expected %h, actual %h", want.ch, o_ascii_char);
                failures++;
            end
            if (o_last !== want.last) begin
                $error("last: expected %b, actual %b", want.last, o_last);
                failures++;
            end
            if (o_overflow !== want.ovf) begin
                $error("overflow: expected %b, actual %b", want.ovf, o_overflow);
                failures++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && out_ready)
            check_beat();
    end

    // output back-pressure: mostly short stalls, now and then a long one
    always @(posedge i_clk) begin
        int roll;
        if (!receiver_stalls_on) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                out_ready <= 1'b1;
            end else begin
                out_ready  <= 1'b0;
                stall_left <= (roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        if (!sender_gaps_on)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // called at a clock edge; returns at the edge where the beat is taken
    task automatic send_value(input logic [VALUE_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid    <= 1'b1;
        fixed_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        format_value(value);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_PRECISION)
            cfg_precision = data[PREC_REG_W-1:0];
        else if (idx == CFG_BUF_SIZE)
            cfg_buf_size = data[BUF_REG_W-1:0];
        @(posedge i_clk);
    endtask

    task automatic set_config(input int prec, input int buf_chars);
        wait_idle();
        // upper nibble of the precision write should be ignored
        write_reg(CFG_PRECISION, {4'($urandom_range(0, 15)), 4'(prec)});
        write_reg(CFG_BUF_SIZE, CFG_DATA_W'(buf_chars));
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [INT_W-1:0]     ip;
        logic [FRAC_BITS-1:0] fr;
        int                   base;
        fr = FRAC_BITS'($urandom);
        case ($urandom_range(0, 6))
            0, 1: return $urandom;
            2: ip = INT_W'($urandom_range(0, 200) - 100);
            3: begin
                // around the decimal digit-count boundaries
                base = 10 ** $urandom_range(0, 4);
                base -= $urandom_range(0, 1);
                if ($urandom_range(0, 1))
                    base = -base;
                ip = INT_W'(base);
            end
            4: ip = $urandom_range(0, 1) ? INT_W'(65535) : INT_W'(-65536);
            default: begin
                ip = INT_W'($urandom);
                case ($urandom_range(0, 3))
                    0: fr = '0;
                    1: fr = FRAC_BITS'(1);
                    2: fr = '1;
                    default: fr = FRAC_BITS'(1 << (FRAC_BITS - 1));
                endcase
            end
        endcase
        return {ip, fr};
    endfunction

    // reset settings: precision 5, sixteen characters
    task automatic test_default_extremes();
        wait_idle();
        send_value(32'h0000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFF);
        send_value(32'h0000_8000);
        send_value(32'hFFFF_8000);
        send_value(32'h0000_7FFF);
        send_value(32'h0000_0001);
    endtask

    // text ends on the point; also precision above the clamp
    task automatic test_precision_zero();
        set_config(0, 16);
        send_value(32'h0001_8000);
        send_value(32'hFFFF_4000);
        set_config(15, 255);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0001);
    endtask

    task automatic test_text_too_long();
        set_config(5, 0);
        send_value(32'h0000_0000);
        set_config(5, 13);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        set_config(5, 12);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        set_config(5, 8);
        send_value(32'h0000_0000);
        send_value(32'hFFFF_FFFF);
        set_config(0, 3);
        send_value(32'h0000_7FFF);
        send_value(32'hFFFF_8000);
    endtask

    task automatic test_random_phases();
        int prec;
        int buf_chars;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: begin prec = 5; buf_chars = 16; end
                1: begin prec = 0; buf_chars = $urandom_range(3, 8); end
                2: begin prec = 15; buf_chars = 255; end
                3: begin prec = $urandom_range(0, 15); buf_chars = $urandom_range(0, 4); end
                4: begin prec = $urandom_range(0, 15); buf_chars = $urandom_range(0, 255); end
                default: begin
                    prec      = $urandom_range(0, 15);
                    buf_chars = $urandom_range(5, 14);
                end
            endcase
            set_config(prec, buf_chars);
            // a couple of phases run back to back with no idling at all
            sender_gaps_on     = !(phase == 0 || phase == 6);
            receiver_stalls_on = !(phase == 0 || phase == 6);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_value(random_value());
        end
        wait_idle();
        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_extremes();
        test_precision_zero();
        test_text_too_long();
        test_random_phases();
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
